@@ rtl/siad_pkg.sv @@
// Shared constants and types for the signed integer ALU with divide and power.
// No dependencies; imported by siad_div and signed_integer_alu_div_pow.
package siad_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REM = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_POW = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/siad_div.sv @@
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on siad_pkg (DATA_WIDTH, CNT_W, div_stat_t).
module siad_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [siad_pkg::DATA_WIDTH-1:0] dividend,
  input  logic [siad_pkg::DATA_WIDTH-1:0] divisor,
  output logic [siad_pkg::DATA_WIDTH-1:0] quotient,
  output logic [siad_pkg::DATA_WIDTH-1:0] remainder,
  output siad_pkg::div_stat_t             stat
);
  import siad_pkg::*;

  logic [DATA_WIDTH-1:0] dvsr;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;

  assign shifted = {remainder, quotient[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        remainder <= '0;
        quotient  <= dividend;
        dvsr      <= divisor;
        cnt       <= CNT_W'(DATA_WIDTH);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (!diff[DATA_WIDTH]) begin
          remainder <= diff[DATA_WIDTH-1:0];
          quotient  <= {quotient[DATA_WIDTH-2:0], 1'b1};
        end else begin
          remainder <= shifted[DATA_WIDTH-1:0];
          quotient  <= {quotient[DATA_WIDTH-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/signed_integer_alu_div_pow.sv @@
// Signed integer ALU: add, sub, mul, div, rem, pow on two's complement operands.
// Sequencer with one shared multiplier; depends on siad_pkg and siad_div.
//
// Usage: an item (func, operand_a, operand_b) is taken on in_valid & in_ready;
// exactly one result (result_value, status) follows on out_valid/out_ready.
// in_ready is high only while the sequencer is idle: one item at a time.
// States from accept to out_valid, with the receiver ready:
//   add, sub, mul, error codes, power with exponent <= 0: S_START, S_FIN
//   div, rem: S_START, S_DIV (one quotient bit per cycle in the divider), S_FIN
//   pow: S_START, then S_PMUL and S_PSQ per exponent bit up to its highest
//        set bit, a final S_PMUL and S_FIN; each exponent bit costs a multiply
//        and a square through the single shared multiplier.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished item is held in the sequencer
// until the output register frees, and no new item is taken meanwhile.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid;
// there is no stored state beyond the item in flight.
module signed_integer_alu_div_pow (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [siad_pkg::FUNC_W-1:0]             func,
  input  logic signed [siad_pkg::DATA_WIDTH-1:0]  operand_a,
  input  logic signed [siad_pkg::DATA_WIDTH-1:0]  operand_b,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [siad_pkg::DATA_WIDTH-1:0]  result_value,
  output logic [siad_pkg::STATUS_W-1:0]           status
);
  import siad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_PMUL,
    S_PSQ,
    S_FIN
  } state_t;

  state_t state;

  logic [FUNC_W-1:0]     func_r;
  logic [DATA_WIDTH-1:0] a_r, b_r;
  logic [DATA_WIDTH-1:0] acc, sq, expo;
  logic [DATA_WIDTH-1:0] res_r;
  logic [STATUS_W-1:0]   st_r;

  logic                  a_neg, b_neg;
  logic [DATA_WIDTH-1:0] mag_a, mag_b;

  logic [DATA_WIDTH-1:0]   mul_x, mul_y;
  logic [DATA_WIDTH-1:0]   mul_lo;

  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_q, div_r;
  div_stat_t             dstat;

  assign a_neg = a_r[DATA_WIDTH-1];
  assign b_neg = b_r[DATA_WIDTH-1];
  assign mag_a = a_neg ? (~a_r + 1'b1) : a_r;
  assign mag_b = b_neg ? (~b_r + 1'b1) : b_r;

  // shared multiplier, low half only
  always_comb begin
    case (state)
      S_PMUL: begin
        mul_x = acc;
        mul_y = sq;
      end
      S_PSQ: begin
        mul_x = sq;
        mul_y = sq;
      end
      default: begin
        mul_x = a_r;
        mul_y = b_r;
      end
    endcase
  end

  assign mul_lo = mul_x * mul_y;

  assign div_start = (state == S_START) && (func_r == FUNC_DIV || func_r == FUNC_REM)
                     && (b_r != '0);

  siad_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag_a),
    .divisor   (mag_b),
    .quotient  (div_q),
    .remainder (div_r),
    .stat      (dstat)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= func;
            a_r    <= operand_a;
            b_r    <= operand_b;
            state  <= S_START;
          end
        end
        S_START: begin
          st_r  <= ST_OK;
          res_r <= '0;
          state <= S_FIN;
          case (func_r)
            FUNC_ADD: res_r <= a_r + b_r;
            FUNC_SUB: res_r <= a_r - b_r;
            FUNC_MUL: res_r <= mul_lo;
            FUNC_DIV, FUNC_REM: begin
              if (b_r == '0) begin
                st_r <= ST_DIVZERO;
              end else begin
                state <= S_DIV;
              end
            end
            FUNC_POW: begin
              if (b_neg || b_r == '0) begin
                res_r <= DATA_WIDTH'(1);
              end else begin
                acc   <= DATA_WIDTH'(1);
                sq    <= a_r;
                expo  <= b_r;
                state <= S_PMUL;
              end
            end
            default: st_r <= ST_UNKNOWN;
          endcase
        end
        S_DIV: begin
          if (dstat.done) begin
            if (func_r == FUNC_DIV) begin
              res_r <= (a_neg != b_neg) ? (~div_q + 1'b1) : div_q;
            end else begin
              res_r <= a_neg ? (~div_r + 1'b1) : div_r;
            end
            state <= S_FIN;
          end
        end
        S_PMUL: begin
          if (expo == '0) begin
            res_r <= acc;
            state <= S_FIN;
          end else begin
            if (expo[0]) begin
              acc <= mul_lo;
            end
            state <= S_PSQ;
          end
        end
        S_PSQ: begin
          sq    <= mul_lo;
          expo  <= expo >> 1;
          state <= S_PMUL;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            result_value <= res_r;
            status       <= st_r;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted item always takes the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready still high after accept");

  // divider completion only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // waiting on the divider means the divider is running or finishing
  a_div_alive: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dstat.busy || dstat.done))
    else $error("divide state with idle divider");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_value == '0))
    else $error("nonzero value with error status");

endmodule
